// File: rtl/sste_pkg.sv
package sste_pkg;

	typedef logic [7:0] seg_byte_t;
	typedef logic [6:0] glyph_t;

	localparam logic [7:0] CHAR_PERIOD = 8'h2E;
	localparam logic [7:0] CHAR_COLON  = 8'h3A;
	localparam logic [7:0] GLYPH_BASE  = 8'h20;
	localparam seg_byte_t  POINT_BIT   = 8'h80;
	localparam int         GLYPH_SPAN  = 96;
	localparam int         QUEUE_DEPTH = 2;

	// segments a-g in bits 0-6, codes 0x20..0x7F
	localparam glyph_t GLYPH_ROM [GLYPH_SPAN] = '{
		7'h00, 7'h06, 7'h22, 7'h5C, 7'h6D, 7'h52, 7'h7D, 7'h02,
		7'h39, 7'h0F, 7'h76, 7'h46, 7'h0C, 7'h40, 7'h08, 7'h52,
		7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07,
		7'h7F, 7'h6F, 7'h10, 7'h0C, 7'h58, 7'h48, 7'h7D, 7'h53,
		7'h7B, 7'h77, 7'h7C, 7'h58, 7'h5E, 7'h79, 7'h71, 7'h3D,
		7'h76, 7'h06, 7'h1E, 7'h74, 7'h38, 7'h55, 7'h37, 7'h3F,
		7'h73, 7'h67, 7'h77, 7'h6D, 7'h78, 7'h3E, 7'h3E, 7'h7E,
		7'h76, 7'h6E, 7'h5B, 7'h39, 7'h64, 7'h0F, 7'h23, 7'h10,
		7'h20, 7'h5F, 7'h7C, 7'h58, 7'h5E, 7'h7B, 7'h71, 7'h6F,
		7'h74, 7'h04, 7'h0E, 7'h74, 7'h38, 7'h55, 7'h54, 7'h5C,
		7'h73, 7'h67, 7'h50, 7'h6D, 7'h78, 7'h1C, 7'h1C, 7'h1C,
		7'h76, 7'h6E, 7'h5B, 7'h39, 7'h06, 7'h0F, 7'h04, 7'h7F
	};

	function automatic glyph_t glyph_of(input logic [7:0] code);
		logic [6:0] idx;
		idx = code[6:0] - GLYPH_BASE[6:0];
		if (code < GLYPH_BASE || code[7]) begin
			return '0;
		end
		return GLYPH_ROM[idx];
	endfunction

endpackage

// File: rtl/sste_if.sv
interface sste_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       last_char;

	modport source (output valid, output char_code, output last_char, input ready);
	modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface sste_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] group_index;
	logic [7:0] segment_byte;
	logic       last_group;

	modport source (output valid, output group_index, output segment_byte,
		output last_group, input ready);
	modport sink   (input valid, input group_index, input segment_byte,
		input last_group, output ready);
endinterface

// File: rtl/sste_front.sv
module sste_front import sste_pkg::*; #(
	parameter int DIGIT_COUNT = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	sste_in_if.sink                      text,
	output logic                         push,
	output logic [DIGIT_COUNT-1:0][7:0]  push_data,
	input  logic                         full
);

	localparam int DW = $clog2(DIGIT_COUNT + 1);

	logic [1:0]                   chars_seen_q;
	logic [DW-1:0]                digits_filled_q;
	logic [DIGIT_COUNT-1:0][7:0]  buf_q;
	logic [DIGIT_COUNT-1:0][7:0]  buf_next;
	logic [DW-1:0]                point_grp;
	logic                         early;
	logic                         is_dot;
	logic                         is_colon;
	logic                         colon_ok;
	logic                         put_ok;
	logic                         point_ok;
	logic                         accept;
	glyph_t                       glyph;

	assign text.ready = !full;
	assign accept     = text.valid && text.ready;

	always_comb begin
		early     = chars_seen_q < 2'd2;
		is_dot    = text.char_code == CHAR_PERIOD;
		is_colon  = text.char_code == CHAR_COLON;
		colon_ok  = !early && is_colon && digits_filled_q == DW'(2);
		point_ok  = !early && is_dot && digits_filled_q >= DW'(2);
		put_ok    = (early || (!is_dot && !colon_ok))
			&& digits_filled_q < DW'(DIGIT_COUNT);
		point_grp = (digits_filled_q == DW'(2)) ? '0 : digits_filled_q - DW'(1);
		glyph     = glyph_of(text.char_code);
		for (int i = 0; i < DIGIT_COUNT; i++) begin
			buf_next[i] = buf_q[i];
			if (put_ok && digits_filled_q == DW'(i)) begin
				buf_next[i] = buf_next[i] | {1'b0, glyph};
			end
			if (point_ok && point_grp == DW'(i)) begin
				buf_next[i] = buf_next[i] | POINT_BIT;
			end
			if (colon_ok && i == 1) begin
				buf_next[i] = buf_next[i] | POINT_BIT;
			end
		end
	end

	assign push      = accept && text.last_char;
	assign push_data = buf_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chars_seen_q    <= '0;
			digits_filled_q <= '0;
			buf_q           <= '0;
		end else if (accept) begin
			if (text.last_char) begin
				chars_seen_q    <= '0;
				digits_filled_q <= '0;
				buf_q           <= '0;
			end else begin
				if (early) begin
					chars_seen_q <= chars_seen_q + 2'd1;
				end
				if (put_ok) begin
					digits_filled_q <= digits_filled_q + DW'(1);
				end
				buf_q <= buf_next;
			end
		end
	end

endmodule

// File: rtl/sste_queue.sv
module sste_queue import sste_pkg::*; #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] head
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] entry_q [QUEUE_DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = count_q == CW'(QUEUE_DEPTH);
	assign empty   = count_q == '0;
	assign head    = entry_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// File: rtl/sste_back.sv
module sste_back import sste_pkg::*; #(
	parameter int DIGIT_COUNT = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         empty,
	input  logic [DIGIT_COUNT-1:0][7:0]  head,
	output logic                         pop,
	sste_out_if.source                   groups
);

	localparam int GW = $clog2(DIGIT_COUNT);

	logic [GW-1:0] grp_q;
	logic          at_end;
	logic          taken;

	assign at_end              = grp_q == GW'(DIGIT_COUNT - 1);
	assign taken               = groups.valid && groups.ready;
	assign groups.valid        = !empty;
	assign groups.group_index  = grp_q[1:0];
	assign groups.segment_byte = head[grp_q];
	assign groups.last_group   = at_end;
	assign pop                 = taken && at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_q <= '0;
		end else if (taken) begin
			grp_q <= at_end ? '0 : grp_q + GW'(1);
		end
	end

endmodule

// File: rtl/seven_segment_text_encoder.sv
// Channel   Dir  Payload                                               Request
// text      in   char_code[7:0], last_char                             one character
// groups    out  group_index[1:0], segment_byte[7:0], last_group       one group byte
//
// The front takes one character per cycle while text.ready is high and folds
// it into the string buffer in the same cycle; a closing character hands the
// finished buffer to a two-entry queue. The back emits one group byte per
// cycle while groups.ready is high, DIGIT_COUNT bytes per string, so the
// groups port sets the rate for short strings. Reset clears the string
// state and empties the queue. text.ready drops only while the queue holds
// two finished strings; groups stalls never block the front otherwise.
module seven_segment_text_encoder import sste_pkg::*; #(
	parameter int DIGIT_COUNT = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	sste_in_if.sink     text,
	sste_out_if.source  groups
);

	// front to queue
	logic                         push;
	logic [DIGIT_COUNT-1:0][7:0]  push_data;
	logic                         full;
	// queue to back
	logic                         pop;
	logic                         empty;
	logic [DIGIT_COUNT-1:0][7:0]  head;

	// accept and classify characters, build the string buffer
	sste_front #(.DIGIT_COUNT(DIGIT_COUNT)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.text      (text),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	// hold finished strings so each side can stall on its own
	sste_queue #(.WIDTH(DIGIT_COUNT * 8)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.empty     (empty),
		.head      (head)
	);

	// advance through the groups of the head string
	sste_back #(.DIGIT_COUNT(DIGIT_COUNT)) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (empty),
		.head   (head),
		.pop    (pop),
		.groups (groups)
	);

endmodule
